// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the plotter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/nspp_pkg.sv =====
// Shared types, constants and helper functions of the noise sphere plotter.
// No dependencies; every RTL module imports this package.
package nspp_pkg;

  localparam int SCREEN_MAX_X = 639;
  localparam int SCREEN_MAX_Y = 479;

  localparam logic [9:0] PIX_MAX_X = 10'(SCREEN_MAX_X);
  localparam logic [9:0] PIX_MAX_Y = 10'(SCREEN_MAX_Y);

  // Screen geometry for one view and for three views.
  localparam int SC1_X  = SCREEN_MAX_X / 2;
  localparam int MID1_Y = SCREEN_MAX_Y / 2;
  localparam int SCALE1 = (MID1_Y < SC1_X) ? MID1_Y : SC1_X;
  localparam int SC3_X  = SCREEN_MAX_X / 4;
  localparam int MID3_Y = SCREEN_MAX_Y / 4;
  localparam int SCALE3 = (MID3_Y < SC3_X) ? MID3_Y : SC3_X;

  localparam logic signed [12:0] MID1_A  = 13'(SC1_X);
  localparam logic signed [12:0] MID1_YV = 13'(MID1_Y);
  localparam logic signed [12:0] MID3_A  = 13'(SC3_X);
  localparam logic signed [12:0] MID3_B  = 13'(3 * SC3_X);
  localparam logic signed [12:0] MID3_YV = 13'(MID3_Y);
  localparam logic signed [12:0] MID3_Y3 = 13'(3 * MID3_Y);
  localparam logic signed [12:0] LIM_X   = 13'(SCREEN_MAX_X);
  localparam logic signed [12:0] LIM_Y   = 13'(SCREEN_MAX_Y);
  localparam logic signed [17:0] SCALE1_V = 18'(SCALE1);
  localparam logic signed [17:0] SCALE3_V = 18'(SCALE3);

  // Sine polynomial coefficients (Q16) and phase constants.
  localparam logic [16:0] POLY_A  = 17'd102944;
  localparam logic [16:0] POLY_B  = 17'd42048;
  localparam logic [16:0] POLY_C  = 17'd4640;
  localparam logic [16:0] Z_ONE   = 17'h10000;
  localparam logic [17:0] QUARTER = 18'h10000;
  localparam logic [29:0] ROOT_BIT0 = 30'h1000_0000;

  localparam logic [3:0] TRIG_N   = 4'd10;
  localparam logic [4:0] MAC_LAST = 5'd18;

  typedef enum logic [2:0] {
    CFG_WIDE   = 3'd0,
    CFG_THREE  = 3'd1,
    CFG_STRIDE = 3'd2,
    CFG_KEEP   = 3'd3,
    CFG_TURN_X = 3'd4,
    CFG_TURN_Y = 3'd5,
    CFG_TURN_Z = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VIEW_XY = 2'd0,
    VIEW_YZ = 2'd1,
    VIEW_ZX = 2'd2
  } view_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TRIG,
    BK_MAC,
    BK_EMIT
  } bk_state_t;

  typedef enum logic [2:0] {
    SN_IDLE,
    SN_SQ,
    SN_C,
    SN_B,
    SN_OUT
  } sn_state_t;

  typedef enum logic [2:0] {
    K_ONE,
    K_FIRST,
    K_ADD,
    K_SUB,
    K_PROJ
  } mac_kind_t;

  typedef enum logic [3:0] {
    D_NONE,
    D_RS,
    D_X,
    D_Y,
    D_Z,
    D_T,
    D_YX,
    D_ZY,
    D_ZX,
    D_PX,
    D_PY,
    D_PZ
  } mac_dest_t;

  typedef struct packed {
    logic              wide;
    logic              three;
    logic [7:0]        stride;
    logic [7:0]        keep;
    logic signed [9:0] tx;
    logic signed [9:0] ty;
    logic signed [9:0] tz;
  } nspp_cfg_t;

  // One plotted point: newest, middle and oldest sample as Q0.16.
  typedef struct packed {
    logic [15:0] n0;
    logic [15:0] n1;
    logic [15:0] n2;
  } nspp_pt_t;

  // Whole degrees to a phase with 2^18 units per turn, rounded.
  // 2^18 = 360 * 728 + 64, so only the small remainder needs a reciprocal.
  function automatic logic [17:0] deg_phase(input logic signed [9:0] d);
    logic signed [10:0] m;
    logic [8:0]         dm;
    logic [14:0]        x;
    logic [30:0]        q;
    logic [17:0]        base;
    if (d >= 10'sd360) begin
      m = 11'(d) - 11'sd360;
    end else if (d < -10'sd360) begin
      m = 11'(d) + 11'sd720;
    end else if (d < 10'sd0) begin
      m = 11'(d) + 11'sd360;
    end else begin
      m = 11'(d);
    end
    dm   = m[8:0];
    x    = {dm, 6'b0} + 15'd180;
    q    = 31'(x) * 31'd46604;
    base = 18'(dm) * 18'd728;
    return base + 18'(q[30:24]);
  endfunction

  // Q15 rounding of a product or sum, half away from zero.
  function automatic logic signed [17:0] round15(input logic signed [36:0] v);
    logic [36:0] mag;
    logic [36:0] rr;
    mag = v[36] ? 37'(-v) : 37'(v);
    rr  = (mag + 37'd16384) >> 15;
    return v[36] ? 18'(-rr) : 18'(rr);
  endfunction

  function automatic logic [9:0] clamp_pix(input logic signed [12:0] v,
                                           input logic signed [12:0] hi);
    if (v < 13'sd0) begin
      return 10'd0;
    end else if (v > hi) begin
      return hi[9:0];
    end
    return v[9:0];
  endfunction

endpackage

// ===== hdl/nspp_fifo.sv =====
// Two-entry queue of points between the sample front end and the back end.
// Depends on nspp_pkg for the point type.
module nspp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nspp_pkg::nspp_pt_t din,
  output logic              full,
  input  logic              pop,
  output nspp_pkg::nspp_pt_t dout,
  output logic              empty
);
  import nspp_pkg::*;

  nspp_pt_t   mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// ===== hdl/nspp_front.sv =====
// Front end: sample window, stride and keep counters; queues plotted points.
// Depends on nspp_pkg for the configuration and point types.
module nspp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  nspp_pkg::nspp_cfg_t cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_sample,
  input  logic               q_full,
  output logic               push,
  output nspp_pkg::nspp_pt_t entry
);
  import nspp_pkg::*;

  logic [15:0] w0_r, w1_r;
  logic [1:0]  fill_r, fill_nxt;
  logic [7:0]  strc_r, strc_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [15:0] s_new;
  logic [7:0]  stride;
  logic        form, keep, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    s_new    = cfg.wide ? in_sample : {in_sample[7:0], 8'h00};
    stride   = (cfg.stride == 8'd0) ? 8'd1 : cfg.stride;
    fill_nxt = fill_r;
    strc_nxt = strc_r;
    skip_nxt = skip_r;
    form     = 1'b0;
    keep     = 1'b0;
    if (fill_r != 2'd3) begin
      fill_nxt = fill_r + 2'd1;
      if (fill_nxt == 2'd3) begin
        form     = 1'b1;
        strc_nxt = 8'd0;
      end
    end else begin
      strc_nxt = strc_r + 8'd1;
      // A stride lowered mid-count still fires once the count passes it.
      if (strc_nxt >= stride) begin
        form     = 1'b1;
        strc_nxt = 8'd0;
      end
    end
    if (form) begin
      if (cfg.keep == 8'd0) begin
        keep     = 1'b1;
        skip_nxt = 8'd0;
      end else begin
        keep     = (skip_r == 8'd0);
        skip_nxt = (({1'b0, skip_r} + 9'd1) >= {1'b0, cfg.keep}) ? 8'd0 : skip_r + 8'd1;
      end
    end
  end

  assign push     = accept && form && keep;
  assign entry.n0 = s_new;
  assign entry.n1 = w0_r;
  assign entry.n2 = w1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      strc_r <= 8'd0;
      skip_r <= 8'd0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      strc_r <= strc_nxt;
      skip_r <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w0_r <= s_new;
      w1_r <= w0_r;
    end
  end

endmodule

// ===== hdl/nspp_root.sv =====
// Bit-pair square root of a Q0.16 sample scaled by 2^14, one step per cycle.
// Depends on nspp_pkg for the start bit constant.
module nspp_root (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] value,
  output logic        busy,
  output logic [14:0] root
);
  import nspp_pkg::*;

  logic [29:0] bit_r, rem_r, res_r, trial;

  assign busy  = (bit_r != 30'd0);
  assign trial = res_r + bit_r;
  assign root  = res_r[14:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 30'd0;
    end else if (start) begin
      bit_r <= ROOT_BIT0;
    end else if (busy) begin
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {value, 14'd0};
      res_r <= 30'd0;
    end else if (busy) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
    end
  end

endmodule

// ===== hdl/nspp_sine.sv =====
// Q15 sine of an 18-bit phase: quarter-wave odd polynomial on one multiplier.
// Depends on nspp_pkg for coefficients and the state type.
module nspp_sine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [17:0]        phase,
  output logic               busy,
  output logic               done,
  output logic signed [16:0] value
);
  import nspp_pkg::*;

  sn_state_t          st_r, st_nxt;
  logic [1:0]         quad_r;
  logic [16:0]        z_r, z2_r, t_r;
  logic               done_r;
  logic signed [16:0] val_r;
  logic [16:0]        ma, mb, hi;
  logic [33:0]        prod;
  logic [16:0]        s15;

  assign busy  = (st_r != SN_IDLE);
  assign done  = done_r;
  assign value = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SN_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == SN_OUT);
    end
  end

  always_comb begin
    st_nxt = st_r;
    ma     = 17'd0;
    mb     = 17'd0;
    unique case (st_r)
      SN_IDLE: begin
        if (start) st_nxt = SN_SQ;
      end
      SN_SQ: begin
        ma     = z_r;
        mb     = z_r;
        st_nxt = SN_C;
      end
      SN_C: begin
        ma     = POLY_C;
        mb     = z2_r;
        st_nxt = SN_B;
      end
      SN_B: begin
        ma     = t_r;
        mb     = z2_r;
        st_nxt = SN_OUT;
      end
      SN_OUT: begin
        ma     = t_r;
        mb     = z_r;
        st_nxt = SN_IDLE;
      end
      default: st_nxt = SN_IDLE;
    endcase
  end

  assign prod = 34'(ma) * 34'(mb);
  assign hi   = prod[32:16];
  assign s15  = 17'((18'(hi) + 18'd1) >> 1);

  always_ff @(posedge clk) begin
    case (st_r)
      SN_IDLE: begin
        if (start) begin
          quad_r <= phase[17:16];
          // Odd quadrants run the quarter wave backwards.
          z_r    <= phase[16] ? Z_ONE - {1'b0, phase[15:0]} : {1'b0, phase[15:0]};
        end
      end
      SN_SQ:  z2_r  <= hi;
      SN_C:   t_r   <= POLY_B - hi;
      SN_B:   t_r   <= POLY_A - hi;
      SN_OUT: val_r <= quad_r[1] ? -$signed(s15) : $signed(s15);
      default: ;
    endcase
  end

endmodule

// ===== hdl/nspp_back.sv =====
// Back end: spherical to Cartesian, three rotations and projection on one
// shared multiplier, then pixel emission. Uses nspp_sine and nspp_root.
module nspp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  nspp_pkg::nspp_cfg_t cfg,
  input  logic               q_empty,
  input  nspp_pkg::nspp_pt_t q_dout,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_view,
  output logic [9:0]         out_pixel_x,
  output logic [9:0]         out_pixel_y,
  output logic               out_last
);
  import nspp_pkg::*;

  bk_state_t          st_r, st_nxt;
  nspp_pt_t           smp_r;
  logic [17:0]        phz_r, phx_r, phy_r;
  logic [3:0]         idx_r;
  logic               pend_r;
  logic signed [16:0] trg_r [10];
  logic [4:0]         step_r;
  logic               ph_r;
  logic signed [35:0] prod_r, acc_r;
  logic signed [17:0] rs_r, x_r, y_r, z_r, t_r;
  logic signed [11:0] pjx_r, pjy_r, pjz_r;
  view_t              vw_r, vw_nxt;
  logic               out_valid_r, out_last_r;
  logic [1:0]         out_view_r;
  logic [9:0]         out_px_r, out_py_r;

  logic               sn_go, sn_busy, sn_done;
  logic signed [16:0] sn_val;
  logic [17:0]        sn_phase;
  logic               rt_busy;
  logic [14:0]        rt_root;
  logic               load_ok, emit_go;
  logic signed [17:0] ma, mb, r_op, scale;
  mac_kind_t          kind;
  mac_dest_t          dest;
  logic signed [36:0] sum_w, pj_sum;
  logic signed [17:0] rnd_w;
  logic signed [11:0] pj_w;
  logic signed [12:0] cx, cy;
  logic [9:0]         pix_x, pix_y;
  logic               pix_last;

  nspp_sine u_sine (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sn_go),
    .phase (sn_phase),
    .busy  (sn_busy),
    .done  (sn_done),
    .value (sn_val)
  );

  nspp_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pop),
    .value (q_dout.n0),
    .busy  (rt_busy),
    .root  (rt_root)
  );

  assign load_ok = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    pop     = 1'b0;
    sn_go   = 1'b0;
    emit_go = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop    = 1'b1;
          st_nxt = BK_TRIG;
        end
      end
      BK_TRIG: begin
        if (!pend_r && !sn_busy && !sn_done && idx_r != TRIG_N) sn_go = 1'b1;
        if (idx_r == TRIG_N && !rt_busy) st_nxt = BK_MAC;
      end
      BK_MAC: begin
        if (ph_r && step_r == MAC_LAST) st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (load_ok) begin
          emit_go = 1'b1;
          if (pix_last) st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Trig table order: st, ct, sp, cp, then cos/sin for the z, x, y turns.
  always_comb begin
    case (idx_r)
      4'd0:    sn_phase = {1'b0, smp_r.n1, 1'b0};
      4'd1:    sn_phase = {1'b0, smp_r.n1, 1'b0} + QUARTER;
      4'd2:    sn_phase = {smp_r.n2, 2'b00};
      4'd3:    sn_phase = {smp_r.n2, 2'b00} + QUARTER;
      4'd4:    sn_phase = phz_r + QUARTER;
      4'd5:    sn_phase = phz_r;
      4'd6:    sn_phase = phx_r + QUARTER;
      4'd7:    sn_phase = phx_r;
      4'd8:    sn_phase = phy_r + QUARTER;
      4'd9:    sn_phase = phy_r;
      default: sn_phase = 18'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (sn_go) begin
      pend_r <= 1'b1;
    end else if (sn_done) begin
      pend_r <= 1'b0;
    end
  end

  assign r_op  = 18'($signed({1'b0, rt_root}));
  assign scale = cfg.three ? SCALE3_V : SCALE1_V;

  // Each step multiplies once; two-product steps keep the first in acc_r.
  always_comb begin
    ma   = 18'sd0;
    mb   = 18'sd0;
    kind = K_ONE;
    dest = D_NONE;
    case (step_r)
      5'd0:  begin ma = r_op; mb = 18'(trg_r[2]); dest = D_RS; end
      5'd1:  begin ma = rs_r; mb = 18'(trg_r[1]); dest = D_X;  end
      5'd2:  begin ma = rs_r; mb = 18'(trg_r[0]); dest = D_Y;  end
      5'd3:  begin ma = r_op; mb = 18'(trg_r[3]); dest = D_Z;  end
      5'd4:  begin ma = x_r;  mb = 18'(trg_r[4]); kind = K_FIRST; end
      5'd5:  begin ma = y_r;  mb = 18'(trg_r[5]); kind = K_ADD; dest = D_T;  end
      5'd6:  begin ma = y_r;  mb = 18'(trg_r[4]); kind = K_FIRST; end
      5'd7:  begin ma = x_r;  mb = 18'(trg_r[5]); kind = K_SUB; dest = D_YX; end
      5'd8:  begin ma = y_r;  mb = 18'(trg_r[6]); kind = K_FIRST; end
      5'd9:  begin ma = z_r;  mb = 18'(trg_r[7]); kind = K_ADD; dest = D_T;  end
      5'd10: begin ma = z_r;  mb = 18'(trg_r[6]); kind = K_FIRST; end
      5'd11: begin ma = y_r;  mb = 18'(trg_r[7]); kind = K_SUB; dest = D_ZY; end
      5'd12: begin ma = x_r;  mb = 18'(trg_r[8]); kind = K_FIRST; end
      5'd13: begin ma = z_r;  mb = 18'(trg_r[9]); kind = K_ADD; dest = D_T;  end
      5'd14: begin ma = z_r;  mb = 18'(trg_r[8]); kind = K_FIRST; end
      5'd15: begin ma = x_r;  mb = 18'(trg_r[9]); kind = K_SUB; dest = D_ZX; end
      5'd16: begin ma = scale; mb = x_r; kind = K_PROJ; dest = D_PX; end
      5'd17: begin ma = scale; mb = y_r; kind = K_PROJ; dest = D_PY; end
      5'd18: begin ma = scale; mb = z_r; kind = K_PROJ; dest = D_PZ; end
      default: ;
    endcase
  end

  always_comb begin
    case (kind)
      K_ADD:   sum_w = 37'(acc_r) + 37'(prod_r);
      K_SUB:   sum_w = 37'(acc_r) - 37'(prod_r);
      default: sum_w = 37'(prod_r);
    endcase
  end

  assign rnd_w  = round15(sum_w);
  // Projection rounds toward plus infinity.
  assign pj_sum = (sum_w + 37'sd32767) >>> 15;
  assign pj_w   = pj_sum[11:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      smp_r  <= q_dout;
      phz_r  <= deg_phase(cfg.tz);
      phx_r  <= deg_phase(cfg.tx);
      phy_r  <= deg_phase(cfg.ty);
      idx_r  <= 4'd0;
      step_r <= 5'd0;
      ph_r   <= 1'b0;
      vw_r   <= VIEW_XY;
    end else begin
      if (sn_done) begin
        trg_r[idx_r] <= sn_val;
        idx_r        <= idx_r + 4'd1;
      end
      if (st_r == BK_MAC) begin
        ph_r <= ~ph_r;
        if (!ph_r) begin
          prod_r <= ma * mb;
        end else begin
          step_r <= step_r + 5'd1;
          if (kind == K_FIRST) acc_r <= prod_r;
          case (dest)
            D_RS: rs_r <= rnd_w;
            D_X:  x_r  <= rnd_w;
            D_Y:  y_r  <= rnd_w;
            D_Z:  z_r  <= rnd_w;
            D_T:  t_r  <= rnd_w;
            D_YX: begin y_r <= rnd_w; x_r <= t_r; end
            D_ZY: begin z_r <= rnd_w; y_r <= t_r; end
            D_ZX: begin z_r <= rnd_w; x_r <= t_r; end
            D_PX: pjx_r <= pj_w;
            D_PY: pjy_r <= pj_w;
            D_PZ: pjz_r <= pj_w;
            default: ;
          endcase
        end
      end
      if (emit_go) vw_r <= vw_nxt;
    end
  end

  always_comb begin
    vw_nxt   = vw_r;
    cx       = 13'sd0;
    cy       = 13'sd0;
    pix_last = 1'b1;
    if (!cfg.three) begin
      cx = MID1_A + 13'(pjx_r);
      cy = MID1_YV - 13'(pjy_r);
    end else begin
      case (vw_r)
        VIEW_XY: begin
          cx       = MID3_A + 13'(pjx_r);
          cy       = MID3_YV - 13'(pjy_r);
          pix_last = 1'b0;
          vw_nxt   = VIEW_YZ;
        end
        VIEW_YZ: begin
          cx       = MID3_B + 13'(pjy_r);
          cy       = MID3_YV - 13'(pjz_r);
          pix_last = 1'b0;
          vw_nxt   = VIEW_ZX;
        end
        default: begin
          cx = MID3_A + 13'(pjz_r);
          cy = MID3_Y3 - 13'(pjx_r);
        end
      endcase
    end
    pix_x = clamp_pix(cx, LIM_X);
    pix_y = clamp_pix(cy, LIM_Y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_view_r <= cfg.three ? vw_r : VIEW_XY;
      out_px_r   <= pix_x;
      out_py_r   <= pix_y;
      out_last_r <= pix_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_view    = out_view_r;
  assign out_pixel_x = out_px_r;
  assign out_pixel_y = out_py_r;
  assign out_last    = out_last_r;

endmodule

// ===== hdl/noise_sphere_pixel_plotter_unit.sv =====
// A sample that forms a plotted point pushes it into the two-entry point
// queue; the back end pops it and runs ten sine evaluations, then 19
// multiply steps on the shared back-end multiplier, then one pixel a cycle
// while out_stall is low. It pops the next point only after the last pixel
// of the one before; samples are accepted whenever the queue has room.
// Reset (synchronous, active low) clears counters, queue and control state.
`include "assert_macros.svh"

module noise_sphere_pixel_plotter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_view,
  output logic [9:0]  out_pixel_x,
  output logic [9:0]  out_pixel_y,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);
  import nspp_pkg::*;

  nspp_cfg_t cfg_r;
  nspp_pt_t  q_din, q_dout;
  logic      q_push, q_pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide   <= 1'b0;
      cfg_r.three  <= 1'b0;
      cfg_r.stride <= 8'd1;
      cfg_r.keep   <= 8'd0;
      cfg_r.tx     <= 10'sd0;
      cfg_r.ty     <= 10'sd0;
      cfg_r.tz     <= 10'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDE:   cfg_r.wide   <= cfg_wdata[0];
        CFG_THREE:  cfg_r.three  <= cfg_wdata[0];
        CFG_STRIDE: cfg_r.stride <= cfg_wdata[7:0];
        CFG_KEEP:   cfg_r.keep   <= cfg_wdata[7:0];
        CFG_TURN_X: cfg_r.tx     <= cfg_wdata;
        CFG_TURN_Y: cfg_r.ty     <= cfg_wdata;
        CFG_TURN_Z: cfg_r.tz     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  nspp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_full    (q_full),
    .push      (q_push),
    .entry     (q_din)
  );

  nspp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  nspp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_dout      (q_dout),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_view    (out_view),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_last    (out_last)
  );

  `ASSERT_IMP(a_pix_x_range, clk, rst_n, out_valid, out_pixel_x <= PIX_MAX_X, "column off screen")
  `ASSERT_IMP(a_pix_y_range, clk, rst_n, out_valid, out_pixel_y <= PIX_MAX_Y, "row off screen")
  `ASSERT_IMP(a_zx_is_last, clk, rst_n, out_valid && out_view == VIEW_ZX, out_last, "zx not last")
  `ASSERT_NXT(a_burst_cont, clk, rst_n, out_valid && !out_last, out_valid, "pixel burst broken")

endmodule
